>>> rtl/core/pl_pkg.sv
// Package for the positional list block: sizes, operation codes and status codes.
// Used by positional_list_insert_delete_top; depends on nothing else.
package pl_pkg;

  // Store size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CAPT = 6'b000100,
    S_MOVE = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

>>> rtl/core/positional_list_insert_delete_top.sv
// Positional list: ordered store of signed words with insert, delete, retrieve,
// replace, clear and traverse. Depends on pl_pkg.
//
//   channel | handshake            | fields
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_stall  | op, position, value
//   output  | out_valid / out_stall| read_value, status, count, full_res, empty_res, last
//
// Insert and delete move the later entries one word per cycle through the write
// port and the registered read port of the entry memory.
// Retrieve passes the read, capture and output states, replace the final write and
// output, refused requests only output; traverse repeats read, capture and output per entry.
// Reset empties the list at once; entries are not cleared and need no pass.
// A result waits in the output register while out_stall is high; no new item is
// taken until the last result of the current item has left.
module positional_list_insert_delete_top
  import pl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         op,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] read_value,
  output logic [ST_W-1:0]         status,
  output logic [CNT_W-1:0]        count,
  output logic                    full_res,
  output logic                    empty_res,
  output logic                    last
);

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [ADDR_W-1:0]       src;
  logic [CNT_W-1:0]        moves;
  logic                    rd_pend;
  logic [ADDR_W-1:0]       pend_dst;
  logic [OP_W-1:0]         req_op;
  logic [ADDR_W-1:0]       req_pos;
  logic signed [VAL_W-1:0] req_val;
  logic signed [VAL_W-1:0] out_value;
  logic [ST_W-1:0]         out_status;
  logic                    out_last;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    in_acc;

  assign in_acc = in_valid && !in_stall;

  // Memory write port: shifted words during a move, the request value at the end.
  assign mem_we    = (state == S_MOVE && rd_pend) || (state == S_FIN);
  assign mem_waddr = (state == S_FIN) ? req_pos : pend_dst;
  assign mem_wdata = (state == S_FIN) ? req_val : rd_data;

  // Entry memory with one write port and a registered read port at src.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[src];
  end

  // Handshake and result ports.
  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign read_value = out_value;
  assign status     = out_status;
  assign count      = cnt;
  assign full_res   = (cnt == CNT_W'(CAPACITY));
  assign empty_res  = (cnt == '0);
  assign last       = out_last;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_INSERT: begin
                if (cnt >= CNT_W'(CAPACITY)) begin
                  state <= S_OUT;
                end else if (position > cnt) begin
                  state <= S_OUT;
                end else begin
                  rd_pend <= 1'b0;
                  state   <= S_MOVE;
                end
              end
              OP_DELETE, OP_RETRIEVE, OP_TRAVERSE: begin
                if (cnt == '0 || (op != OP_TRAVERSE && position >= cnt)) begin
                  state <= S_OUT;
                end else begin
                  state <= S_READ;
                end
              end
              OP_REPLACE: begin
                if (cnt == '0 || position >= cnt) begin
                  state <= S_OUT;
                end else begin
                  state <= S_FIN;
                end
              end
              OP_CLEAR: begin
                cnt   <= '0;
                state <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CAPT;
        end
        S_CAPT: begin
          if (req_op == OP_DELETE) begin
            rd_pend <= 1'b0;
            state   <= S_MOVE;
          end else begin
            state <= S_OUT;
          end
        end
        S_MOVE: begin
          if (moves != '0) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (req_op == OP_INSERT) begin
              state <= S_FIN;
            end else begin
              cnt   <= cnt - CNT_W'(1);
              state <= S_OUT;
            end
          end
        end
        S_FIN: begin
          if (req_op == OP_INSERT) begin
            cnt <= cnt + CNT_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (req_op == OP_TRAVERSE && !out_last) begin
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: request copy, addresses and the result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          req_op     <= op;
          req_pos    <= position[ADDR_W-1:0];
          req_val    <= value;
          out_value  <= '0;
          out_last   <= 1'b1;
          out_status <= ST_OK;
          case (op)
            OP_INSERT: begin
              if (cnt >= CNT_W'(CAPACITY)) begin
                out_status <= ST_FULL;
              end else if (position > cnt) begin
                out_status <= ST_RANGE;
              end
              src   <= ADDR_W'(cnt - CNT_W'(1));
              moves <= cnt - position;
            end
            OP_DELETE, OP_RETRIEVE, OP_REPLACE: begin
              if (cnt == '0) begin
                out_status <= ST_EMPTY;
              end else if (position >= cnt) begin
                out_status <= ST_RANGE;
              end
              src <= position[ADDR_W-1:0];
            end
            OP_TRAVERSE: begin
              if (cnt == '0) begin
                out_status <= ST_EMPTY;
              end
              src <= '0;
            end
            default: begin
              src <= '0;
            end
          endcase
        end
      end
      S_CAPT: begin
        out_value <= rd_data;
        if (req_op == OP_DELETE) begin
          src   <= req_pos + ADDR_W'(1);
          moves <= cnt - CNT_W'(1) - CNT_W'(req_pos);
        end else if (req_op == OP_TRAVERSE) begin
          out_last <= ((CNT_W'(src) + CNT_W'(1)) == cnt);
        end
      end
      S_MOVE: begin
        // Issue the next read; its word is written one slot over next cycle.
        if (moves != '0) begin
          moves <= moves - CNT_W'(1);
          if (req_op == OP_INSERT) begin
            pend_dst <= src + ADDR_W'(1);
            src      <= src - ADDR_W'(1);
          end else begin
            pend_dst <= src - ADDR_W'(1);
            src      <= src + ADDR_W'(1);
          end
        end
      end
      S_OUT: begin
        if (!out_stall && req_op == OP_TRAVERSE && !out_last) begin
          src <= src + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // A memory write only comes from a move or the final write of insert or replace.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_MOVE || state == S_FIN))
    else $error("entry memory written outside a move or final write");

  // The entry count never exceeds the store size.
  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A clear empties the list by the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_CLEAR) |=> (cnt == '0))
    else $error("clear did not empty the list");

  // A taken result that is not the last one continues a traverse.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_last) |=> (state == S_READ))
    else $error("traverse did not continue after a non-final result");

  // A pending moved word always targets a slot at or below the entry count.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && rd_pend) |-> (CNT_W'(pend_dst) <= cnt))
    else $error("shift writes beyond the end of the list");

endmodule
